// ===== rtl/core/nec_ir_frame_decoder_top_assert.svh =====
// Assertion macros shared by the decoder RTL.
// Each macro checks one property on the rising clock edge, and is held off while reset is high.
`ifndef NEC_IR_FRAME_DECODER_TOP_ASSERT_SVH
`define NEC_IR_FRAME_DECODER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NECIR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NECIR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/necir_pkg.sv =====
`timescale 1ns / 1ps
package necir_pkg;

   localparam int unsigned TICK_WIDTH  = 16;
   localparam int unsigned BYTE_WIDTH  = 8;
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned FRAME_WIDTH = 32;
   localparam int unsigned BIT_COUNT_WIDTH = $clog2(FRAME_WIDTH);

   localparam logic [BIT_COUNT_WIDTH-1:0] BIT_COUNT_LAST = BIT_COUNT_WIDTH'(FRAME_WIDTH - 1);

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_NOMINAL    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REPEAT_NOMINAL   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ZERO_NOMINAL     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ONE_NOMINAL      = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEADER_TOLERANCE = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BIT_TOLERANCE    = 3'd5;

   // Configuration reset values.
   localparam logic [TICK_WIDTH-1:0] START_NOMINAL_RESET    = 16'd12480;
   localparam logic [TICK_WIDTH-1:0] REPEAT_NOMINAL_RESET   = 16'd10368;
   localparam logic [TICK_WIDTH-1:0] ZERO_NOMINAL_RESET     = 16'd1032;
   localparam logic [TICK_WIDTH-1:0] ONE_NOMINAL_RESET      = 16'd2074;
   localparam logic [TICK_WIDTH-1:0] HEADER_TOLERANCE_RESET = 16'd500;
   localparam logic [TICK_WIDTH-1:0] BIT_TOLERANCE_RESET    = 16'd300;

   typedef enum logic [1:0] {
      PHASE_IDLE   = 2'd0,
      PHASE_HEADER = 2'd1,
      PHASE_DATA   = 2'd2
   } phase_type;

   typedef struct packed {
      logic [TICK_WIDTH-1:0] start_nominal;
      logic [TICK_WIDTH-1:0] repeat_nominal;
      logic [TICK_WIDTH-1:0] zero_nominal;
      logic [TICK_WIDTH-1:0] one_nominal;
      logic [TICK_WIDTH-1:0] header_tolerance;
      logic [TICK_WIDTH-1:0] bit_tolerance;
   } cfg_type;

   typedef struct packed {
      logic                  frame_ready;
      logic                  frame_rejected;
      logic                  repeat_seen;
      logic [BYTE_WIDTH-1:0] address_out;
      logic [BYTE_WIDTH-1:0] command_out;
   } rsp_type;

   // True when nom - tol < v < nom + tol, evaluated without wrap. The lower
   // bound is rewritten as v + tol > nom so that everything stays unsigned.
   function automatic logic necir_in_window(logic [TICK_WIDTH-1:0] v,
                                            logic [TICK_WIDTH-1:0] nom,
                                            logic [TICK_WIDTH-1:0] tol);
      logic [TICK_WIDTH:0] low_sum;
      logic [TICK_WIDTH:0] high_sum;
      low_sum  = {1'b0, v} + {1'b0, tol};
      high_sum = {1'b0, nom} + {1'b0, tol};
      return (low_sum > {1'b0, nom}) && ({1'b0, v} < high_sum);
   endfunction

endpackage

// ===== rtl/core/necir_if.sv =====
`timescale 1ns / 1ps
// Input channel: one word is one falling edge with its measured interval.
interface necir_req_if
   import necir_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [TICK_WIDTH-1:0] interval_ticks;

   modport source (output valid, output interval_ticks, input ready);
   modport sink (input valid, input interval_ticks, output ready);
endinterface

// Result channel: one word per input edge.
interface necir_rsp_if
   import necir_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic                  frame_ready;
   logic                  frame_rejected;
   logic                  repeat_seen;
   logic [BYTE_WIDTH-1:0] address_out;
   logic [BYTE_WIDTH-1:0] command_out;

   modport source (output valid, output frame_ready, output frame_rejected,
                   output repeat_seen, output address_out, output command_out,
                   input ready);
   modport sink (input valid, input frame_ready, input frame_rejected,
                 input repeat_seen, input address_out, input command_out,
                 output ready);
endinterface

// ===== rtl/core/necir_engine.sv =====
`timescale 1ns / 1ps
module necir_engine
   import necir_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [TICK_WIDTH-1:0] ticks,
   input  cfg_type               cfg,
   output rsp_type               result
);

   phase_type                  phase_ff, phase_in;
   logic [BIT_COUNT_WIDTH-1:0] bit_count_ff, bit_count_in;
   logic [FRAME_WIDTH-1:0]     frame_ff, frame_in;
   logic [BYTE_WIDTH-1:0]      address_ff, address_in;
   logic [BYTE_WIDTH-1:0]      command_ff, command_in;

   logic start_hit, repeat_hit, zero_hit, one_hit, bit_good, last_bit, checks_pass;

   assign start_hit  = necir_in_window(ticks, cfg.start_nominal, cfg.header_tolerance);
   assign repeat_hit = necir_in_window(ticks, cfg.repeat_nominal, cfg.header_tolerance);
   assign zero_hit   = necir_in_window(ticks, cfg.zero_nominal, cfg.bit_tolerance);
   assign one_hit    = necir_in_window(ticks, cfg.one_nominal, cfg.bit_tolerance);
   assign bit_good   = zero_hit || one_hit;
   assign last_bit   = (bit_count_ff == BIT_COUNT_LAST);

   // Both byte pairs must be bitwise complements, checked on the frame that
   // already includes the bit arriving now.
   assign checks_pass = (frame_in[7:0] == ~frame_in[15:8]) &&
                        (frame_in[23:16] == ~frame_in[31:24]);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         unique case (phase_ff)
            PHASE_HEADER: begin
               phase_in = start_hit ? PHASE_DATA : PHASE_IDLE;
            end
            PHASE_DATA: begin
               phase_in = (bit_good && !last_bit) ? PHASE_DATA : PHASE_IDLE;
            end
            default: begin
               phase_in = PHASE_HEADER;
            end
         endcase
      end
   end

   // Frame assembly, latches and the result word.
   always_comb begin
      bit_count_in = bit_count_ff;
      frame_in     = frame_ff;
      address_in   = address_ff;
      command_in   = command_ff;
      result       = '0;
      if (step) begin
         unique case (phase_ff)
            PHASE_HEADER: begin
               bit_count_in       = '0;
               result.repeat_seen = !start_hit && repeat_hit;
            end
            PHASE_DATA: begin
               if (bit_good) begin
                  // The zero window wins where the two bit windows overlap.
                  frame_in[bit_count_ff] = !zero_hit;
               end
               if (!bit_good || last_bit) begin
                  bit_count_in = '0;
               end else begin
                  bit_count_in = bit_count_ff + 1'b1;
               end
               if (bit_good && last_bit) begin
                  result.frame_ready    = checks_pass;
                  result.frame_rejected = !checks_pass;
                  if (checks_pass) begin
                     address_in = frame_in[7:0];
                     command_in = frame_in[23:16];
                  end
               end
            end
            default: begin
               bit_count_in = '0;
            end
         endcase
      end
      result.address_out = address_in;
      result.command_out = command_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_IDLE;
         bit_count_ff <= '0;
         frame_ff     <= '0;
         address_ff   <= '0;
         command_ff   <= '0;
      end else begin
         phase_ff     <= phase_in;
         bit_count_ff <= bit_count_in;
         frame_ff     <= frame_in;
         address_ff   <= address_in;
         command_ff   <= command_in;
      end
   end

endmodule

// ===== rtl/core/nec_ir_frame_decoder_top.sv =====
// NEC infrared frame decoder: one input word per receiver falling edge.
// A result word is registered on rsp_if after its input word passes the input register and the decode stage.
// Throughput: one word per cycle while rsp_if is ready, set by the single decode stage between the
// input register and the result register; a stall on rsp_if backs up into req_if.ready.
// Reset (synchronous, active high): phase idle, bit count and latches zero,
// configuration registers back to their default NEC timing values.
`timescale 1ns / 1ps
`include "nec_ir_frame_decoder_top_assert.svh"
module nec_ir_frame_decoder_top
   import necir_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   necir_req_if.sink                  req_if,
   necir_rsp_if.source                rsp_if,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [TICK_WIDTH-1:0]      csr_write_data
);

   // Configuration registers. Writes to indexes past the last register are
   // dropped.
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_START_NOMINAL:    cfg_in.start_nominal    = csr_write_data;
            CSR_REPEAT_NOMINAL:   cfg_in.repeat_nominal   = csr_write_data;
            CSR_ZERO_NOMINAL:     cfg_in.zero_nominal     = csr_write_data;
            CSR_ONE_NOMINAL:      cfg_in.one_nominal      = csr_write_data;
            CSR_HEADER_TOLERANCE: cfg_in.header_tolerance = csr_write_data;
            CSR_BIT_TOLERANCE:    cfg_in.bit_tolerance    = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_nominal    <= START_NOMINAL_RESET;
         cfg_ff.repeat_nominal   <= REPEAT_NOMINAL_RESET;
         cfg_ff.zero_nominal     <= ZERO_NOMINAL_RESET;
         cfg_ff.one_nominal      <= ONE_NOMINAL_RESET;
         cfg_ff.header_tolerance <= HEADER_TOLERANCE_RESET;
         cfg_ff.bit_tolerance    <= BIT_TOLERANCE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The input register holds one word. The decode stage fires when that word
   // is present and the result register is free or being emptied this cycle,
   // so a new word can enter every cycle while the output keeps flowing.
   logic                  in_valid_ff, in_valid_in;
   logic [TICK_WIDTH-1:0] ticks_ff, ticks_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   rsp_type               decoded;
   logic                  fire;
   logic                  req_take;

   assign fire     = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_take = req_if.valid && req_if.ready;

   assign req_if.ready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      ticks_in    = ticks_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         ticks_in    = req_if.interval_ticks;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   // The decode engine keeps the phase, bit counter, frame and latches and
   // advances them exactly once per word that passes through the stage.
   necir_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (fire),
      .ticks  (ticks_ff),
      .cfg    (cfg_ff),
      .result (decoded)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_in       = decoded;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ticks_ff <= ticks_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.frame_ready    = rsp_ff.frame_ready;
   assign rsp_if.frame_rejected = rsp_ff.frame_rejected;
   assign rsp_if.repeat_seen    = rsp_ff.repeat_seen;
   assign rsp_if.address_out    = rsp_ff.address_out;
   assign rsp_if.command_out    = rsp_ff.command_out;

   // A decoded edge always lands in the result register.
   `NECIR_ASSERT_NEXT(a_fire_fills_rsp, fire, rsp_valid_ff,
      "decoded word did not reach the result register")

   // At most one of the three event flags can describe a single edge.
   `NECIR_ASSERT_NOW(a_flags_exclusive, rsp_valid_ff,
      $onehot0({rsp_ff.frame_ready, rsp_ff.frame_rejected, rsp_ff.repeat_seen}),
      "more than one event flag set in one result word")

   // A word waiting in the input register is neither lost nor altered.
   `NECIR_ASSERT_NEXT(a_input_held, in_valid_ff && !fire, in_valid_ff && $stable(ticks_ff),
      "pending input word was dropped or changed while stalled")

endmodule
